>>> design/pidtw_pkg.sv
package pidtw_pkg;

  // Field and state widths.
  localparam int SAMPLE_W    = 16;
  localparam int DERIV_W     = SAMPLE_W + 1;
  localparam int INTEG_W     = 32;
  localparam int GAIN_W      = 32;
  localparam int SQUARE_W    = 2 * SAMPLE_W;
  localparam int SQ_W        = 40;
  localparam int WIN_W       = 10;
  localparam int WINDOW_MAX  = 1023;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  typedef logic signed [GAIN_W-1:0] gain_t;
  typedef logic signed [GAIN_W+1:0] gain_wide_t;
  typedef logic [SQ_W-1:0] sq_t;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_KP     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KI     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KD     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TUNE   = 3'd4;

  // Configuration reset values.
  localparam gain_t KP_RESET = 32'sd13107;
  localparam gain_t KI_RESET = 32'sd66;
  localparam gain_t KD_RESET = 32'sd196608;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 10'd100;

  // Gain slots, in search order.
  localparam logic [1:0] GAIN_P = 2'd0;
  localparam logic [1:0] GAIN_D = 2'd1;
  localparam logic [1:0] GAIN_I = 2'd2;

  // Twiddle search stages.
  localparam logic [1:0] STAGE_ADD     = 2'd0;
  localparam logic [1:0] STAGE_SUB     = 2'd1;
  localparam logic [1:0] STAGE_RESTORE = 2'd2;
  localparam logic [1:0] STAGE_IDLE    = 2'd3;

  // Reciprocal of 5 (shift 34) and of 10 (shift 35), exact for 32-bit operands.
  localparam logic [31:0] RECIP_5_10 = 32'hCCCC_CCCD;

  // Saturate a widened gain value to the gain width.
  function automatic gain_t sat_gain(input gain_wide_t x);
    gain_wide_t hi;
    gain_wide_t lo;
    hi = gain_wide_t'({1'b0, {(GAIN_W-1){1'b1}}});
    lo = -hi - gain_wide_t'(1);
    if (x > hi) begin
      sat_gain = hi[GAIN_W-1:0];
    end else if (x < lo) begin
      sat_gain = lo[GAIN_W-1:0];
    end else begin
      sat_gain = x[GAIN_W-1:0];
    end
  endfunction

endpackage

>>> design/pid_error_tracker_twiddle_tune_core.sv
// A request is captured in the input register and then passes to the result register.
// Throughput: one request per cycle while result_stall is low; the input register
// takes a new request while a result waits if it is empty, else sample_stall rises.
// The per-request cost is set by one 16x16 square (ahead of the input register)
// and one 40-bit add and compare in the state update.
// Reset (synchronous, active high) loads the register defaults and clears state;
// the gain steps are filled from the gains on the first cycle after reset or a write.
module pid_error_tracker_twiddle_tune_core (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [pidtw_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [pidtw_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                    sample_valid,
  output logic                                    sample_stall,
  input  logic signed [pidtw_pkg::SAMPLE_W-1:0]   cross_track_error,
  output logic                                    result_valid,
  input  logic                                    result_stall,
  output logic signed [pidtw_pkg::SAMPLE_W-1:0]   prop_error,
  output logic signed [pidtw_pkg::DERIV_W-1:0]    deriv_error,
  output logic signed [pidtw_pkg::INTEG_W-1:0]    integ_error,
  output logic signed [pidtw_pkg::GAIN_W-1:0]     gain_p,
  output logic signed [pidtw_pkg::GAIN_W-1:0]     gain_i,
  output logic signed [pidtw_pkg::GAIN_W-1:0]     gain_d,
  output logic [pidtw_pkg::SQ_W-1:0]              window_error,
  output logic                                    window_end,
  output logic                                    gains_improved,
  output logic [1:0]                              tuned_index
);

  // Configuration registers.
  pidtw_pkg::gain_t                 kp_initial;
  pidtw_pkg::gain_t                 ki_initial;
  pidtw_pkg::gain_t                 kd_initial;
  logic [pidtw_pkg::WIN_W-1:0]      window_length;
  logic                             tune_enable;
  pidtw_pkg::gain_t                 kp_next;
  pidtw_pkg::gain_t                 ki_next;
  pidtw_pkg::gain_t                 kd_next;
  logic [pidtw_pkg::WIN_W-1:0]      window_length_next;
  logic                             tune_enable_next;
  logic                             cfg_hit;
  logic                             cfg_load;

  // Tracker and search state.
  logic                                   first_pending;
  logic signed [pidtw_pkg::SAMPLE_W-1:0]  previous_sample;
  logic signed [pidtw_pkg::INTEG_W-1:0]   integral_sum;
  logic [pidtw_pkg::WIN_W-1:0]            step_in_window;
  pidtw_pkg::sq_t                         squared_sum;
  pidtw_pkg::sq_t                         best_squared_sum;
  pidtw_pkg::gain_t                       gains [3];
  pidtw_pkg::gain_t                       gain_steps [3];
  logic [1:0]                             search_index;
  logic [1:0]                             search_stage;
  logic                                   reload;

  // Input register.
  logic                                   s1_valid;
  logic signed [pidtw_pkg::SAMPLE_W-1:0]  s1_cte;
  logic [pidtw_pkg::SQUARE_W-1:0]         s1_sq;
  logic signed [pidtw_pkg::SQUARE_W-1:0]  square_full;
  logic                                   advance;
  logic                                   sample_take;
  logic                                   s1_fire;

  // Configuration write decode; any known index reinitializes the block.
  always_comb begin
    kp_next            = kp_initial;
    ki_next            = ki_initial;
    kd_next            = kd_initial;
    window_length_next = window_length;
    tune_enable_next   = tune_enable;
    cfg_hit            = 1'b1;
    case (cfg_index)
      pidtw_pkg::REG_KP:     kp_next = cfg_data[pidtw_pkg::GAIN_W-1:0];
      pidtw_pkg::REG_KI:     ki_next = cfg_data[pidtw_pkg::GAIN_W-1:0];
      pidtw_pkg::REG_KD:     kd_next = cfg_data[pidtw_pkg::GAIN_W-1:0];
      pidtw_pkg::REG_WINDOW: window_length_next = cfg_data[pidtw_pkg::WIN_W-1:0];
      pidtw_pkg::REG_TUNE:   tune_enable_next = cfg_data[0];
      default:               cfg_hit = 1'b0;
    endcase
  end

  assign cfg_load = cfg_write && cfg_hit;

  // Handshake between the input register and the result register.
  assign advance      = !result_valid || !result_stall;
  assign sample_stall = s1_valid && !advance;
  assign sample_take  = sample_valid && !sample_stall;
  assign s1_fire      = s1_valid && advance;
  assign square_full  = cross_track_error * cross_track_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_take) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_take) begin
      s1_cte <= cross_track_error;
      s1_sq  <= square_full;
    end
  end

  // Error terms of the current request.
  logic [pidtw_pkg::WIN_W-1:0]            win_len;
  logic [pidtw_pkg::WIN_W-1:0]            win_half;
  logic signed [pidtw_pkg::SAMPLE_W-1:0]  prev_use;
  logic signed [pidtw_pkg::DERIV_W-1:0]   deriv;
  logic signed [pidtw_pkg::INTEG_W:0]     integ_wide;
  logic signed [pidtw_pkg::INTEG_W-1:0]   integ_new;
  pidtw_pkg::sq_t                         sq_base;
  logic [pidtw_pkg::SQUARE_W-1:0]         sq_add;
  logic [pidtw_pkg::SQ_W:0]               sq_wide;
  pidtw_pkg::sq_t                         sq_new;
  logic [pidtw_pkg::WIN_W-1:0]            step_next;
  logic                                   wend;
  logic                                   tune;

  always_comb begin
    if (window_length < pidtw_pkg::WIN_W'(2)) begin
      win_len = pidtw_pkg::WIN_W'(2);
    end else if (window_length > pidtw_pkg::WIN_W'(pidtw_pkg::WINDOW_MAX)) begin
      win_len = pidtw_pkg::WIN_W'(pidtw_pkg::WINDOW_MAX);
    end else begin
      win_len = window_length;
    end
    win_half = win_len >> 1;

    prev_use = first_pending ? s1_cte : previous_sample;
    deriv    = {s1_cte[pidtw_pkg::SAMPLE_W-1], s1_cte}
             - {prev_use[pidtw_pkg::SAMPLE_W-1], prev_use};

    integ_wide = {integral_sum[pidtw_pkg::INTEG_W-1], integral_sum}
               + (pidtw_pkg::INTEG_W+1)'(s1_cte);
    if (integ_wide[pidtw_pkg::INTEG_W] != integ_wide[pidtw_pkg::INTEG_W-1]) begin
      integ_new = integ_wide[pidtw_pkg::INTEG_W]
                ? {1'b1, {(pidtw_pkg::INTEG_W-1){1'b0}}}
                : {1'b0, {(pidtw_pkg::INTEG_W-1){1'b1}}};
    end else begin
      integ_new = integ_wide[pidtw_pkg::INTEG_W-1:0];
    end

    // Squared error counts only in the second half of the window.
    sq_base = (step_in_window == '0) ? '0 : squared_sum;
    sq_add  = (step_in_window > win_half) ? s1_sq : '0;
    sq_wide = {1'b0, sq_base} + (pidtw_pkg::SQ_W+1)'(sq_add);
    sq_new  = sq_wide[pidtw_pkg::SQ_W] ? '1 : sq_wide[pidtw_pkg::SQ_W-1:0];

    step_next = (step_in_window >= win_len - 1'b1) ? '0 : step_in_window + 1'b1;
    wend      = (step_next == '0);
    tune      = tune_enable && wend;
  end

  // Step scaling by 1.1 and 0.9 for the gain under search, registered ahead of use.
  pidtw_pkg::gain_t   step_sel;
  logic [31:0]        step_mag;
  logic [31:0]        div10_num;
  logic [63:0]        div10_prod;
  logic [31:0]        q4;
  logic [31:0]        rem10;
  logic [32:0]        up_mag;
  logic [32:0]        down_mag;
  pidtw_pkg::gain_wide_t up_wide;
  pidtw_pkg::gain_wide_t down_wide;
  pidtw_pkg::gain_t   step_up;
  pidtw_pkg::gain_t   step_down;
  logic [1:0]         idx;

  assign idx = (search_index == pidtw_pkg::STAGE_IDLE) ? pidtw_pkg::GAIN_P : search_index;

  always_comb begin
    step_sel   = gain_steps[idx];
    step_mag   = step_sel[pidtw_pkg::GAIN_W-1] ? 32'(~step_sel + 1'b1) : 32'(step_sel);
    div10_num  = step_mag + 32'd4;
    div10_prod = 64'(div10_num) * 64'(pidtw_pkg::RECIP_5_10);
    q4         = 32'(div10_prod[63:35]);
    rem10      = div10_num - ((q4 << 3) + (q4 << 1));
    // Rounding to nearest, ties away from zero; the up step adds one where the quotient falls short on a tie.
    up_mag     = {1'b0, step_mag} + {1'b0, q4} + ((rem10 == 32'd9) ? 33'd1 : 33'd0);
    down_mag   = {1'b0, step_mag} - {1'b0, q4};
    up_wide    = step_sel[pidtw_pkg::GAIN_W-1]
               ? -pidtw_pkg::gain_wide_t'({1'b0, up_mag})
               :  pidtw_pkg::gain_wide_t'({1'b0, up_mag});
    down_wide  = step_sel[pidtw_pkg::GAIN_W-1]
               ? -pidtw_pkg::gain_wide_t'({1'b0, down_mag})
               :  pidtw_pkg::gain_wide_t'({1'b0, down_mag});
  end

  always_ff @(posedge clk) begin
    step_up   <= pidtw_pkg::sat_gain(up_wide);
    step_down <= pidtw_pkg::sat_gain(down_wide);
  end

  // Initial steps are a fifth of each gain, rounded away from zero on ties.
  pidtw_pkg::gain_t step_init [3];

  always_comb begin
    logic [31:0] g_mag;
    logic [63:0] g_prod;
    logic [31:0] g_q;
    for (int k = 0; k < 3; k++) begin
      g_mag  = gains[k][pidtw_pkg::GAIN_W-1] ? 32'(~gains[k] + 1'b1) : 32'(gains[k]);
      g_prod = 64'(g_mag + 32'd2) * 64'(pidtw_pkg::RECIP_5_10);
      g_q    = 32'(g_prod[63:34]);
      step_init[k] = gains[k][pidtw_pkg::GAIN_W-1]
                   ? pidtw_pkg::gain_t'(-$signed({1'b0, g_q}))
                   : pidtw_pkg::gain_t'($signed({1'b0, g_q}));
    end
  end

  // Twiddle search update at a tuned window end.
  pidtw_pkg::gain_t gain_cur;
  pidtw_pkg::gain_t step_cur;
  pidtw_pkg::gain_t gain_plus;
  pidtw_pkg::gain_t gain_minus2;
  pidtw_pkg::gain_t gain_new;
  pidtw_pkg::gain_t step_new;
  pidtw_pkg::gain_t gains_next [3];
  pidtw_pkg::gain_t steps_next [3];
  pidtw_pkg::sq_t   best_next;
  logic [1:0]       index_next;
  logic [1:0]       stage_next;
  logic [1:0]       stage_adv;
  logic [1:0]       idx_inc;
  logic             lt_best;
  logic             improved;

  always_comb begin
    gain_cur    = gains[idx];
    step_cur    = gain_steps[idx];
    gain_plus   = pidtw_pkg::sat_gain(pidtw_pkg::gain_wide_t'(gain_cur)
                                    + pidtw_pkg::gain_wide_t'(step_cur));
    gain_minus2 = pidtw_pkg::sat_gain(pidtw_pkg::gain_wide_t'(gain_cur)
                                    - (pidtw_pkg::gain_wide_t'(step_cur) <<< 1));
    stage_adv   = (search_stage >= pidtw_pkg::STAGE_RESTORE)
                ? pidtw_pkg::STAGE_ADD : search_stage + 2'd1;
    idx_inc     = (idx == pidtw_pkg::GAIN_I) ? pidtw_pkg::GAIN_P : idx + 2'd1;
    lt_best     = sq_new < best_squared_sum;

    gain_new   = gain_cur;
    step_new   = step_cur;
    best_next  = best_squared_sum;
    index_next = search_index;
    stage_next = search_stage;

    if (tune) begin
      stage_next = stage_adv;
      case (stage_adv)
        pidtw_pkg::STAGE_ADD: begin
          gain_new = gain_plus;
        end
        pidtw_pkg::STAGE_SUB: begin
          if (lt_best) begin
            best_next  = sq_new;
            step_new   = step_up;
            index_next = idx_inc;
            stage_next = pidtw_pkg::STAGE_IDLE;
          end else begin
            gain_new = gain_minus2;
          end
        end
        pidtw_pkg::STAGE_RESTORE: begin
          if (lt_best) begin
            best_next = sq_new;
            step_new  = step_up;
          end else begin
            gain_new = gain_plus;
            step_new = step_down;
          end
          index_next = idx_inc;
          stage_next = pidtw_pkg::STAGE_IDLE;
        end
        default: begin
        end
      endcase
    end

    improved = tune && (sq_new <= best_next);

    for (int k = 0; k < 3; k++) begin
      gains_next[k] = (2'(k) == idx) ? gain_new : gains[k];
      steps_next[k] = (2'(k) == idx) ? step_new : gain_steps[k];
    end
  end

  // Configuration, tracker and search state.
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_initial       <= pidtw_pkg::KP_RESET;
      ki_initial       <= pidtw_pkg::KI_RESET;
      kd_initial       <= pidtw_pkg::KD_RESET;
      window_length    <= pidtw_pkg::WINDOW_RESET;
      tune_enable      <= 1'b0;
      gains[pidtw_pkg::GAIN_P] <= pidtw_pkg::KP_RESET;
      gains[pidtw_pkg::GAIN_D] <= pidtw_pkg::KD_RESET;
      gains[pidtw_pkg::GAIN_I] <= pidtw_pkg::KI_RESET;
      first_pending    <= 1'b1;
      previous_sample  <= '0;
      integral_sum     <= '0;
      step_in_window   <= '0;
      squared_sum      <= '0;
      best_squared_sum <= '1;
      search_index     <= pidtw_pkg::GAIN_P;
      search_stage     <= pidtw_pkg::STAGE_IDLE;
      reload           <= 1'b1;
    end else if (cfg_load) begin
      kp_initial       <= kp_next;
      ki_initial       <= ki_next;
      kd_initial       <= kd_next;
      window_length    <= window_length_next;
      tune_enable      <= tune_enable_next;
      gains[pidtw_pkg::GAIN_P] <= kp_next;
      gains[pidtw_pkg::GAIN_D] <= kd_next;
      gains[pidtw_pkg::GAIN_I] <= ki_next;
      first_pending    <= 1'b1;
      previous_sample  <= '0;
      integral_sum     <= '0;
      step_in_window   <= '0;
      squared_sum      <= '0;
      best_squared_sum <= '1;
      search_index     <= pidtw_pkg::GAIN_P;
      search_stage     <= pidtw_pkg::STAGE_IDLE;
      reload           <= 1'b1;
    end else begin
      reload <= 1'b0;
      if (s1_fire) begin
        first_pending    <= 1'b0;
        previous_sample  <= s1_cte;
        integral_sum     <= integ_new;
        step_in_window   <= step_next;
        squared_sum      <= sq_new;
        best_squared_sum <= best_next;
        search_index     <= index_next;
        search_stage     <= stage_next;
        gains            <= gains_next;
      end
    end
  end

  // Gain steps are refilled after reset or a write, else follow the search.
  always_ff @(posedge clk) begin
    if (reload) begin
      gain_steps <= step_init;
    end else if (s1_fire) begin
      gain_steps <= steps_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      prop_error     <= s1_cte;
      deriv_error    <= deriv;
      integ_error    <= integ_new;
      gain_p         <= gains_next[pidtw_pkg::GAIN_P];
      gain_i         <= gains_next[pidtw_pkg::GAIN_I];
      gain_d         <= gains_next[pidtw_pkg::GAIN_D];
      window_error   <= sq_new;
      window_end     <= wend;
      gains_improved <= improved;
      tuned_index    <= index_next;
    end
  end

  // The search never points past the last gain.
  assert property (@(posedge clk) disable iff (rst)
    search_index != pidtw_pkg::STAGE_IDLE)
    else $error("search index out of range");

  // The window position stays below the effective window length.
  assert property (@(posedge clk) disable iff (rst)
    step_in_window < win_len)
    else $error("window position beyond window length");

  // The best score only falls between reinitializations.
  assert property (@(posedge clk) disable iff (rst)
    !cfg_load |=> best_squared_sum <= $past(best_squared_sum))
    else $error("best squared sum increased");

  // An improvement is flagged only on a result that closes a window.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && gains_improved |-> window_end)
    else $error("improvement flagged outside a window end");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pidtw_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 40;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_REQUESTS = 110;
  localparam int PRESSURE_PHASE = 5;
  localparam int SAT_REQUESTS = 72000;
  localparam int DIRECTED_ROWS = 34;
  localparam longint SQ_FULL = (longint'(1) << SQ_W) - 1;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  // One row of the directed table: either a register write or a sample request.
  typedef struct {
    row_kind_e                  kind;
    logic [CFG_INDEX_W-1:0]     index;
    logic [CFG_DATA_W-1:0]      data;
    logic signed [SAMPLE_W-1:0] sample;
    bit                         typed;
    logic signed [SAMPLE_W-1:0] prop;
    logic signed [DERIV_W-1:0]  deriv;
    logic signed [INTEG_W-1:0]  integ;
  } stim_row_t;

  // Error terms that are typed in by hand for a request.
  typedef struct {
    bit                         typed;
    logic signed [SAMPLE_W-1:0] prop;
    logic signed [DERIV_W-1:0]  deriv;
    logic signed [INTEG_W-1:0]  integ;
  } hand_terms_t;

  // Expected outputs of one request.
  typedef struct {
    logic signed [SAMPLE_W-1:0] prop;
    logic signed [DERIV_W-1:0]  deriv;
    logic signed [INTEG_W-1:0]  integ;
    gain_t                      gp;
    gain_t                      gi;
    gain_t                      gd;
    sq_t                        werr;
    logic                       wend;
    logic                       improved;
    logic [1:0]                 idx;
  } pid_terms_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic sample_valid;
  logic sample_stall;
  logic signed [SAMPLE_W-1:0] cross_track_error;
  logic result_valid;
  logic result_stall;
  logic signed [SAMPLE_W-1:0] prop_error;
  logic signed [DERIV_W-1:0] deriv_error;
  logic signed [INTEG_W-1:0] integ_error;
  logic signed [GAIN_W-1:0] gain_p;
  logic signed [GAIN_W-1:0] gain_i;
  logic signed [GAIN_W-1:0] gain_d;
  logic [SQ_W-1:0] window_error;
  logic window_end;
  logic gains_improved;
  logic [1:0] tuned_index;

  pid_error_tracker_twiddle_tune_core DUT (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .sample_valid      (sample_valid),
    .sample_stall      (sample_stall),
    .cross_track_error (cross_track_error),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .prop_error        (prop_error),
    .deriv_error       (deriv_error),
    .integ_error       (integ_error),
    .gain_p            (gain_p),
    .gain_i            (gain_i),
    .gain_d            (gain_d),
    .window_error      (window_error),
    .window_end        (window_end),
    .gains_improved    (gains_improved),
    .tuned_index       (tuned_index)
  );

  always #2 clk = ~clk;

  // Scoreboard bookkeeping.
  pid_terms_t pending_terms[$];
  hand_terms_t hand_checks[$];
  int requests_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  bit tx_paced = 1'b1;
  bit rx_hold_req = 1'b0;
  bit rx_holding = 1'b0;

  // Tracker model: register copies and tracking state.
  gain_t kp_reg, ki_reg, kd_reg;
  logic [WIN_W-1:0] win_reg;
  logic tune_reg;
  bit first_pend;
  longint prev_cte, integ_acc, sq_acc, best_sq;
  int win_pos;
  longint gain_q[3];
  longint step_q[3];
  int srch_idx;
  logic [1:0] srch_stage;

  function automatic longint clamp32(input longint x);
    longint hi;
    longint lo;
    hi = (longint'(1) << (GAIN_W - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // Constant scaling, rounded to nearest with ties away from zero.
  function automatic longint scale_gain(input longint x, input longint num, input longint den);
    longint p;
    longint r;
    p = x * num;
    if (p >= 0) r = (p + den / 2) / den;
    else r = -((-p + den / 2) / den);
    return clamp32(r);
  endfunction

  function automatic void reload_tracker();
    gain_q[GAIN_P] = kp_reg;
    gain_q[GAIN_D] = kd_reg;
    gain_q[GAIN_I] = ki_reg;
    for (int k = 0; k < 3; k++) step_q[k] = scale_gain(gain_q[k], 1, 5);
    first_pend = 1'b1;
    prev_cte = 0;
    integ_acc = 0;
    win_pos = 0;
    sq_acc = 0;
    best_sq = SQ_FULL;
    srch_idx = 0;
    srch_stage = STAGE_IDLE;
  endfunction

  function automatic void apply_reg_write(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_KP: kp_reg = d;
      REG_KI: ki_reg = d;
      REG_KD: kd_reg = d;
      REG_WINDOW: win_reg = d[WIN_W-1:0];
      REG_TUNE: tune_reg = d[0];
      default: return;
    endcase
    reload_tracker();
  endfunction

  // One twiddle move over the gain under search.
  function automatic void advance_search();
    int i;
    i = (srch_idx < 3) ? srch_idx : 0;
    srch_stage = (srch_stage >= STAGE_RESTORE) ? STAGE_ADD : srch_stage + 2'd1;
    if (srch_stage == STAGE_ADD) begin
      gain_q[i] = clamp32(gain_q[i] + step_q[i]);
    end else if (srch_stage == STAGE_SUB) begin
      if (sq_acc < best_sq) begin
        best_sq = sq_acc;
        step_q[i] = scale_gain(step_q[i], 11, 10);
        srch_idx = (i + 1) % 3;
        srch_stage = STAGE_IDLE;
      end else begin
        gain_q[i] = clamp32(gain_q[i] - 2 * step_q[i]);
      end
    end else begin
      if (sq_acc < best_sq) begin
        best_sq = sq_acc;
        step_q[i] = scale_gain(step_q[i], 11, 10);
      end else begin
        gain_q[i] = clamp32(gain_q[i] + step_q[i]);
        step_q[i] = scale_gain(step_q[i], 9, 10);
      end
      srch_idx = (i + 1) % 3;
      srch_stage = STAGE_IDLE;
    end
  endfunction

  function automatic pid_terms_t predict_step(input logic signed [SAMPLE_W-1:0] v);
    pid_terms_t t;
    longint cte;
    longint deriv;
    int len;
    bit closed;
    bit better;
    cte = v;
    len = win_reg;
    if (len < 2) len = 2;
    if (len > WINDOW_MAX) len = WINDOW_MAX;
    better = 1'b0;
    if (first_pend) begin
      prev_cte = cte;
      first_pend = 1'b0;
    end
    if (win_pos == 0) sq_acc = 0;
    deriv = cte - prev_cte;
    prev_cte = cte;
    integ_acc = clamp32(integ_acc + cte);
    // Only the second half of the window counts toward the squared error.
    if (win_pos > len / 2) begin
      sq_acc = sq_acc + cte * cte;
      if (sq_acc > SQ_FULL) sq_acc = SQ_FULL;
    end
    win_pos = (win_pos + 1) % len;
    closed = (win_pos == 0);
    if (tune_reg && closed) begin
      advance_search();
      better = (sq_acc <= best_sq);
    end
    t.prop = v;
    t.deriv = deriv[DERIV_W-1:0];
    t.integ = integ_acc[INTEG_W-1:0];
    t.gp = gain_q[GAIN_P][GAIN_W-1:0];
    t.gi = gain_q[GAIN_I][GAIN_W-1:0];
    t.gd = gain_q[GAIN_D][GAIN_W-1:0];
    t.werr = sq_acc[SQ_W-1:0];
    t.wend = closed;
    t.improved = better;
    t.idx = srch_idx[1:0];
    return t;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Gap length between requests: mostly none, sometimes short, rarely long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(40, 15);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3: return $urandom_range(511) - 256;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_gain();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom_range(1 << 20) - (1 << 19);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [WIN_W-1:0] random_window();
    case ($urandom_range(9))
      0: return '0;
      1: return 10'd1;
      2: return WINDOW_MAX;
      3: return $urandom_range(300, 40);
      default: return $urandom_range(16, 2);
    endcase
  endfunction

  // Offer one sample request and hold it until the block takes it.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] v, input bit typed,
                             input logic signed [SAMPLE_W-1:0] prop,
                             input logic signed [DERIV_W-1:0] deriv,
                             input logic signed [INTEG_W-1:0] integ);
    int gap;
    gap = tx_paced ? pick_gap() : 0;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hand_checks.push_back('{typed, prop, deriv, integ});
    sample_valid <= 1'b1;
    cross_track_error <= v;
    do @(posedge clk); while (sample_stall !== 1'b0);
    requests_sent++;
  endtask

  // Drain every outstanding result, then let the pipeline settle.
  task automatic wait_idle();
    sample_valid <= 1'b0;
    while (results_seen < requests_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    apply_reg_write(idx, d);
  endtask

  // Gain steps are refilled on the cycle after a write.
  task automatic settle_cfg();
    cfg_write <= 1'b0;
    repeat (3) @(posedge clk);
  endtask

  // Directed table: extremes first, then short, saturating and long setups.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_SAMPLE, REG_KP, 32'd0, 16'sh7FFF, 1'b1, 16'sh7FFF, 17'sd0, 32'sd32767},
    '{ROW_SAMPLE, REG_KP, 32'd0, 16'sh8000, 1'b1, 16'sh8000, -17'sd65535, -32'sd1},
    '{ROW_SAMPLE, REG_KP, 32'd0, 16'sh7FFF, 1'b1, 16'sh7FFF, 17'sd65535, 32'sd32766},
    '{ROW_SAMPLE, REG_KP, 32'd0, 16'sh8000, 1'b1, 16'sh8000, -17'sd65535, -32'sd2},
    '{ROW_SAMPLE, REG_KP, 32'd0, 16'sd0, 1'b1, 16'sd0, 17'sd32768, -32'sd2},
    '{ROW_WRITE, REG_WINDOW, 32'd0, 16'sd0, 1'b0, 16'sd0, 17'sd0, 32'sd0},
    '{ROW_WRITE, REG_TUNE, 32'd1, 16'sd0, 1'b0, 16'sd0, 17'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_KP, 32'd0, 16'sh8000, 1'b1, 16'sh8000, 17'sd0, -32'sd32768},
    '{ROW_SAMPLE, REG_KP, 32'd0, 16'sd256, 1'b0, 16'sd0, 17'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_KP, 32'd0, -16'sd1, 1'b0, 16'sd0, 17'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_KP, 32'd0, 16'sd100, 1'b0, 16'sd0, 17'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_KP, 32'd0, 16'sh7FFF, 1'b0, 16'sd0, 17'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_KP, 32'd0, 16'sh8000, 1'b0, 16'sd0, 17'sd0, 32'sd0},
    '{ROW_WRITE, REG_WINDOW, 32'd1, 16'sd0, 1'b0, 16'sd0, 17'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_KP, 32'd0, 16'sd5, 1'b1, 16'sd5, 17'sd0, 32'sd5},
    '{ROW_SAMPLE, REG_KP, 32'd0, -16'sd5, 1'b1, -16'sd5, -17'sd10, 32'sd0},
    '{ROW_SAMPLE, REG_KP, 32'd0, 16'sd1, 1'b0, 16'sd0, 17'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_KP, 32'd0, 16'sd2, 1'b0, 16'sd0, 17'sd0, 32'sd0},
    '{ROW_WRITE, REG_KP, 32'h7FFF_FFFF, 16'sd0, 1'b0, 16'sd0, 17'sd0, 32'sd0},
    '{ROW_WRITE, REG_KI, 32'h8000_0000, 16'sd0, 1'b0, 16'sd0, 17'sd0, 32'sd0},
    '{ROW_WRITE, REG_KD, 32'h8000_0001, 16'sd0, 1'b0, 16'sd0, 17'sd0, 32'sd0},
    '{ROW_WRITE, REG_WINDOW, 32'd3, 16'sd0, 1'b0, 16'sd0, 17'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_KP, 32'd0, 16'sd1000, 1'b1, 16'sd1000, 17'sd0, 32'sd1000},
    '{ROW_SAMPLE, REG_KP, 32'd0, -16'sd2000, 1'b0, 16'sd0, 17'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_KP, 32'd0, 16'sd3000, 1'b0, 16'sd0, 17'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_KP, 32'd0, 16'sh7FFF, 1'b0, 16'sd0, 17'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_KP, 32'd0, 16'sh8000, 1'b0, 16'sd0, 17'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_KP, 32'd0, 16'sd0, 1'b0, 16'sd0, 17'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_KP, 32'd0, 16'sd4, 1'b0, 16'sd0, 17'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_KP, 32'd0, -16'sd4, 1'b0, 16'sd0, 17'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_KP, 32'd0, 16'sd7, 1'b0, 16'sd0, 17'sd0, 32'sd0},
    '{ROW_WRITE, REG_WINDOW, 32'd1023, 16'sd0, 1'b0, 16'sd0, 17'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_KP, 32'd0, 16'sd1, 1'b0, 16'sd0, 17'sd0, 32'sd0},
    '{ROW_SAMPLE, REG_KP, 32'd0, -16'sd1, 1'b0, 16'sd0, 17'sd0, 32'sd0}
  };

  // Compare results against the oldest expectation, then predict new requests.
  always @(posedge clk) begin : result_check
    pid_terms_t want;
    hand_terms_t hand;
    if (rst === 1'b0) begin
      if (result_valid === 1'b1 && result_stall === 1'b0) begin
        results_seen++;
        if (pending_terms.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result expected none, got prop_error %h", $time, prop_error);
        end else begin
          want = pending_terms.pop_front();
          check_field("prop_error", want.prop, prop_error);
          check_field("deriv_error", want.deriv, deriv_error);
          check_field("integ_error", want.integ, integ_error);
          check_field("gain_p", want.gp, gain_p);
          check_field("gain_i", want.gi, gain_i);
          check_field("gain_d", want.gd, gain_d);
          check_field("window_error", want.werr, window_error);
          check_field("window_end", want.wend, window_end);
          check_field("gains_improved", want.improved, gains_improved);
          check_field("tuned_index", want.idx, tuned_index);
        end
      end
      if (sample_valid === 1'b1 && sample_stall === 1'b0) begin
        want = predict_step(cross_track_error);
        hand = hand_checks.pop_front();
        if (hand.typed) begin
          want.prop = hand.prop;
          want.deriv = hand.deriv;
          want.integ = hand.integ;
        end
        pending_terms.push_back(want);
      end
    end
  end

  // Receiver pacing: random stalls, free-running stretches and one long hold.
  initial begin : rx_pace
    int n;
    result_stall <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (rx_hold_req) begin
        rx_holding = 1'b1;
        result_stall <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
        rx_holding = 1'b0;
      end else if ($urandom_range(99) < 4) begin
        result_stall <= 1'b0;
        repeat ($urandom_range(200, 50)) @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          result_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        result_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Watchdog on cycles where nothing moves.
  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (rst !== 1'b0 || cfg_write === 1'b1 ||
        (sample_valid === 1'b1 && sample_stall === 1'b0) ||
        (result_valid === 1'b1 && result_stall === 1'b0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no request or result moved for %0d cycles", $time, idle_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Main stimulus sequence.
  initial begin : stimulus
    stim_row_t row;
    bit in_cfg;
    int mag;
    logic [CFG_DATA_W-1:0] d;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_KP;
    cfg_data <= '0;
    sample_valid <= 1'b0;
    cross_track_error <= '0;
    kp_reg = KP_RESET;
    ki_reg = KI_RESET;
    kd_reg = KD_RESET;
    win_reg = WINDOW_RESET;
    tune_reg = 1'b0;
    reload_tracker();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    repeat (3) @(posedge clk);

    // Directed rows.
    in_cfg = 1'b0;
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      row = directed_rows[r];
      if (row.kind == ROW_WRITE) begin
        if (!in_cfg) wait_idle();
        in_cfg = 1'b1;
        write_reg(row.index, row.data);
      end else begin
        if (in_cfg) settle_cfg();
        in_cfg = 1'b0;
        send_sample(row.sample, row.typed, row.prop, row.deriv, row.integ);
      end
    end

    // Drive the integral into both saturation limits, with tuning running.
    wait_idle();
    write_reg(REG_WINDOW, 32'd100);
    write_reg(REG_TUNE, 32'd1);
    settle_cfg();
    tx_paced = 1'b0;
    for (int k = 0; k < SAT_REQUESTS; k++)
      send_sample($urandom_range(32767, 30000), 1'b0, '0, '0, '0);
    wait_idle();
    write_reg(REG_WINDOW, WINDOW_MAX);
    settle_cfg();
    for (int k = 0; k < SAT_REQUESTS; k++) begin
      mag = $urandom_range(32768, 30000);
      send_sample(-mag, 1'b0, '0, '0, '0);
    end

    // Random phases, each under a fresh configuration.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      write_reg(REG_KP, random_gain());
      write_reg(REG_KI, random_gain());
      write_reg(REG_KD, random_gain());
      d = $urandom();
      d[WIN_W-1:0] = random_window();
      write_reg(REG_WINDOW, d);
      d = $urandom();
      d[0] = ($urandom_range(4) != 0);
      write_reg(REG_TUNE, d);
      if ($urandom_range(2) == 0)
        write_reg(REG_TUNE + CFG_INDEX_W'(1 + $urandom_range(2)), $urandom());
      settle_cfg();
      tx_paced = ($urandom_range(3) != 0);
      if (ph == PRESSURE_PHASE) begin
        // Hold the result side long enough for the block to back up.
        tx_paced = 1'b0;
        rx_hold_req = 1'b1;
        while (!rx_holding) @(posedge clk);
      end
      for (int k = 0; k < PHASE_REQUESTS; k++)
        send_sample(random_sample(), 1'b0, '0, '0, '0);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_terms.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
